// ----- rtl/circle_ring_pixel_classifier_unit_macros.svh -----
// assertion macros for the circle ring pixel classifier
// expects clk and rst_n in the scope where a macro is used
`ifndef CIRCLE_RING_PIXEL_CLASSIFIER_UNIT_MACROS_SVH
`define CIRCLE_RING_PIXEL_CLASSIFIER_UNIT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CRPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define CRPC_ASSERT_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crpc_pkg.sv -----
// shared widths, register indexes and region codes of the circle ring pixel classifier
// no dependencies

package crpc_pkg;

    // field and datapath widths
    localparam int COORD_W      = 12;
    localparam int RADIUS_W     = 11;
    localparam int RCOUNT_W     = 4;
    localparam int COLOR_W      = 24;
    localparam int FHEIGHT_W    = 13;
    localparam int REACH_W      = 13;
    localparam int LO_W         = 12;
    localparam int SQ_W         = 24;
    localparam int D2_W         = 25;
    localparam int RING_IDX_W   = 3;
    localparam int BYTE_W       = 8;

    // configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    // stream widths
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 3;

    // default for the number of ring lanes
    localparam int MAX_RINGS_DEF = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    // region codes
    typedef logic [1:0] region_t;
    localparam region_t REGION_NONE = 2'd0;
    localparam region_t REGION_DISK = 2'd1;
    localparam region_t REGION_RING = 2'd2;
    localparam region_t REGION_RSVD = 2'd3;

    // one classified pixel
    typedef struct packed {
        logic [BYTE_W-1:0]     red_byte;
        logic [BYTE_W-1:0]     green_byte;
        logic [BYTE_W-1:0]     blue_byte;
        logic [RING_IDX_W-1:0] ring_index;
        region_t               region;
        logic                  paint;
    } pixel_result_t;

endpackage

// ----- rtl/circle_ring_pixel_classifier_unit.sv -----
// circle ring pixel classifier: five-stage pipeline, one pixel per clock when not stalled
// throughput: 1 pixel per cycle when the output does not stall, with per-lane 12x12 squarers;
// each stage a register with its own valid bit
// a stalled output only blocks upstream stages that hold data; bubbles fill up first
// reset (rst_n low, asynchronous) empties the pipeline and loads register defaults:
// radius 1, frame height 4096, all other registers 0
// depends on crpc_pkg and circle_ring_pixel_classifier_unit_macros.svh

`include "circle_ring_pixel_classifier_unit_macros.svh"

module circle_ring_pixel_classifier_unit #(
    parameter int MAX_RINGS = crpc_pkg::MAX_RINGS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [crpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [crpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [crpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // ring_index[2:0], blue[10:3],
                                                               // green[18:11], red[26:19], 0
    output logic [crpc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser    // paint[0], region[2:1]
);
    import crpc_pkg::*;

    localparam int RC_W = $clog2(MAX_RINGS + 1);

    // configuration registers
    logic [COORD_W-1:0]   center_x_reg;
    logic [COORD_W-1:0]   center_y_reg;
    logic [RADIUS_W-1:0]  disk_radius_reg;
    logic [RCOUNT_W-1:0]  ring_count_reg;
    logic [COLOR_W-1:0]   fill_color_reg;
    logic                 full_height_reg;
    logic [FHEIGHT_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    // register writes, unused indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            disk_radius_reg  <= RADIUS_W'(1);
            ring_count_reg   <= '0;
            fill_color_reg   <= '0;
            full_height_reg  <= 1'b0;
            frame_height_reg <= FHEIGHT_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:     center_x_reg     <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_W-1:0];
                REG_DISK_RADIUS:  disk_radius_reg  <= cfg_data[RADIUS_W-1:0];
                REG_RING_COUNT:   ring_count_reg   <= cfg_data[RCOUNT_W-1:0];
                REG_FILL_COLOR:   fill_color_reg   <= cfg_data[COLOR_W-1:0];
                REG_FULL_HEIGHT:  full_height_reg  <= cfg_data[0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FHEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // derived configuration values
    logic [RC_W-1:0]    rc_sat;
    logic [REACH_W-1:0] reach;
    logic [LO_W-1:0]    lane_lo [MAX_RINGS];
    logic [MAX_RINGS-1:0] lane_on;

    always_comb
    begin
        if (int'(ring_count_reg) > MAX_RINGS)
            rc_sat = RC_W'(MAX_RINGS);
        else
            rc_sat = RC_W'(ring_count_reg);
        reach = REACH_W'(disk_radius_reg) + REACH_W'(1) + REACH_W'(int'(rc_sat) * 5);
        for (int k = 0; k < MAX_RINGS; k++)
        begin
            lane_lo[k] = LO_W'(disk_radius_reg) + LO_W'(5) + LO_W'(4 * k);
            lane_on[k] = (int'(rc_sat) > k);
        end
    end

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: absolute offsets and drawing box test
    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [COORD_W-1:0] adx_next, ady_next, adx_reg, ady_reg;
    logic               box_next, box1_reg;
    logic [REACH_W-1:0] px_ext, py_ext, cx_ext, ylim;

    assign pixel_x = s_axis_tdata[COORD_W-1:0];
    assign pixel_y = s_axis_tdata[2*COORD_W-1:COORD_W];

    always_comb
    begin
        px_ext = REACH_W'(pixel_x);
        py_ext = REACH_W'(pixel_y);
        cx_ext = REACH_W'(center_x_reg);
        ylim   = full_height_reg ? REACH_W'(frame_height_reg)
                                 : REACH_W'(center_y_reg) + reach;
        adx_next = (pixel_x >= center_x_reg) ? pixel_x - center_x_reg
                                             : center_x_reg - pixel_x;
        ady_next = (pixel_y >= center_y_reg) ? pixel_y - center_y_reg
                                             : center_y_reg - pixel_y;
        box_next = ((px_ext + reach) >= cx_ext) && (px_ext < (cx_ext + reach))
                   && (py_ext < ylim);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            adx_reg  <= adx_next;
            ady_reg  <= ady_next;
            box1_reg <= box_next;
        end
    end

    // stage 2: squares of offsets, radius and lower band edges
    logic [SQ_W-1:0] dx2_reg, dy2_reg, r2_s2_reg;
    logic [SQ_W-1:0] lo2_s2_reg [MAX_RINGS];
    logic            box2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            dx2_reg   <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            dy2_reg   <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
            r2_s2_reg <= SQ_W'(disk_radius_reg) * SQ_W'(disk_radius_reg);
            box2_reg  <= box1_reg;
            for (int k = 0; k < MAX_RINGS; k++)
                lo2_s2_reg[k] <= SQ_W'(lane_lo[k]) * SQ_W'(lane_lo[k]);
        end
    end

    // stage 3: squared distance and upper band edges, (lo+2)^2 = lo^2 + 4lo + 4
    logic [D2_W-1:0] d2_reg;
    logic [SQ_W-1:0] r2_s3_reg;
    logic [SQ_W-1:0] lo2_s3_reg [MAX_RINGS];
    logic [SQ_W-1:0] hi2_s3_reg [MAX_RINGS];
    logic            box3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            d2_reg    <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
            r2_s3_reg <= r2_s2_reg;
            box3_reg  <= box2_reg;
            for (int k = 0; k < MAX_RINGS; k++)
            begin
                lo2_s3_reg[k] <= lo2_s2_reg[k];
                hi2_s3_reg[k] <= lo2_s2_reg[k] + SQ_W'({lane_lo[k], 2'b00}) + SQ_W'(4);
            end
        end
    end

    // stage 4: disk and band compares
    logic                 disk_reg;
    logic [MAX_RINGS-1:0] hit_next, hit_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_RINGS; k++)
            hit_next[k] = box3_reg && lane_on[k]
                          && (D2_W'(lo2_s3_reg[k]) < d2_reg)
                          && (d2_reg < D2_W'(hi2_s3_reg[k]));
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            disk_reg <= box3_reg && (d2_reg <= D2_W'(r2_s3_reg));
            hit_reg  <= hit_next;
        end
    end

    // stage 5: first band wins, build the result
    pixel_result_t res_next, res_reg;
    logic                  found;
    logic [RING_IDX_W-1:0] ring_idx;

    always_comb
    begin
        found    = 1'b0;
        ring_idx = '0;
        for (int k = MAX_RINGS - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
            begin
                found    = 1'b1;
                ring_idx = RING_IDX_W'(k);
            end
        end
        res_next = '0;
        if (disk_reg)
            res_next.region = REGION_DISK;
        else if (found)
        begin
            res_next.region     = REGION_RING;
            res_next.ring_index = ring_idx;
        end
        if (disk_reg || found)
        begin
            res_next.paint      = 1'b1;
            res_next.blue_byte  = fill_color_reg[7:0];
            res_next.green_byte = fill_color_reg[15:8];
            res_next.red_byte   = fill_color_reg[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
            res_reg <= res_next;
    end

    // output packing
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tuser  = {res_reg.region, res_reg.paint};
    assign m_axis_tdata  = {5'b0, res_reg.red_byte, res_reg.green_byte, res_reg.blue_byte,
                            res_reg.ring_index};

    // checks
    `CRPC_ASSERT_IMPLY(a_empty_takes_input, !v5_reg, s_axis_tready, "empty pipeline not ready")
    `CRPC_ASSERT_IMPLY(a_no_rsvd_region, v5_reg, res_reg.region != REGION_RSVD, "bad region")
    `CRPC_ASSERT(a_unpainted_dark,
        !(v5_reg && !res_reg.paint && (m_axis_tdata[26:3] != '0)), "unpainted pixel has color")

endmodule
